[rtl/ray_box_intersection_macros.svh]
// Assertion macros for the ray box intersection block.
// Used by the checker; no other dependencies.
`ifndef RAY_BOX_INTERSECTION_MACROS_SVH
`define RAY_BOX_INTERSECTION_MACROS_SVH

// same-cycle implication, disabled during reset
`define RBI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rbi: implication check failed");

// next-cycle implication, disabled during reset
`define RBI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rbi: next-cycle check failed");

// condition checked at every edge, reset included
`define RBI_ASSERT_ALWAYS(lbl, clk, cond) \
	lbl: assert property (@(posedge clk) (cond)) \
		else $error("rbi: invariant check failed");

`endif

[rtl/rbi_pkg.sv]
// Shared constants and types for the ray box intersection block.
// No dependencies.
`timescale 1ns / 1ps

package rbi_pkg;

	localparam int FRAC_IN = 10;
	localparam int FRAC_T  = 16;
	localparam int LANES   = 6;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic par;
		logic par_fail;
	} axis_flag_t;

endpackage

[rtl/rbi_front.sv]
// Projection front end: offsets, axis dot products, slab numerators.
// Four pipeline stages; depends on rbi_pkg.
`timescale 1ns / 1ps

module rbi_front import rbi_pkg::*; #(
	parameter int CB = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [3*CB-1:0]                ray_origin,
	input  logic [3*CB-1:0]                ray_direction,
	input  logic [3*CB-1:0]                box_axis_x,
	input  logic [3*CB-1:0]                box_axis_y,
	input  logic [3*CB-1:0]                box_axis_z,
	input  logic [3*CB-1:0]                box_position,
	input  logic [3*CB-1:0]                box_min,
	input  logic [3*CB-1:0]                box_max,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [LANES-1:0][2*CB+3:0]     num_mag,
	output logic [LANES-1:0]               num_neg,
	output logic [LANES-1:0][2*CB+1:0]     den_mag,
	output axis_flag_t [2:0]               flags,
	output logic [2:0][3*CB-1:0]           axes
);

	localparam int EW = 2*CB+3;
	localparam int FW = 2*CB+2;
	localparam int NW = 2*CB+4;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [CB:0]       diff_s1 [3];
	logic [2:0][CB-1:0]       dir_s1, lo_s1, hi_s1, lo_s2, hi_s2, lo_s3, hi_s3;
	logic [2:0][3*CB-1:0]     ax_s1, ax_s2, ax_s3, ax_s4;
	logic signed [2*CB:0]     pe_s2 [3][3];
	logic signed [2*CB-1:0]   pf_s2 [3][3];
	logic signed [EW-1:0]     e_s3 [3];
	logic signed [FW-1:0]     f_s3 [3];

	logic [LANES-1:0][NW-1:0] mag_d, mag_s4;
	logic [LANES-1:0]         neg_d, neg_s4;
	logic [LANES-1:0][FW-1:0] den_d, den_s4;
	axis_flag_t [2:0]         flag_d, flag_s4;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int j = 0; j < 3; j++) begin
				diff_s1[j] <= (CB+1)'($signed(box_position[j*CB +: CB]))
					- (CB+1)'($signed(ray_origin[j*CB +: CB]));
			end
			dir_s1 <= ray_direction;
			lo_s1  <= box_min;
			hi_s1  <= box_max;
			ax_s1  <= {box_axis_z, box_axis_y, box_axis_x};
		end
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pe_s2[i][j] <= (2*CB+1)'($signed(ax_s1[i][j*CB +: CB]))
						* (2*CB+1)'(diff_s1[j]);
					pf_s2[i][j] <= (2*CB)'($signed(ax_s1[i][j*CB +: CB]))
						* (2*CB)'($signed(dir_s1[j]));
				end
			end
			lo_s2 <= lo_s1;
			hi_s2 <= hi_s1;
			ax_s2 <= ax_s1;
		end
		if (en3) begin
			for (int i = 0; i < 3; i++) begin
				e_s3[i] <= EW'(pe_s2[i][0]) + EW'(pe_s2[i][1]) + EW'(pe_s2[i][2]);
				f_s3[i] <= FW'(pf_s2[i][0]) + FW'(pf_s2[i][1]) + FW'(pf_s2[i][2]);
			end
			lo_s3 <= lo_s2;
			hi_s3 <= hi_s2;
			ax_s3 <= ax_s2;
		end
		if (en4) begin
			mag_s4  <= mag_d;
			neg_s4  <= neg_d;
			den_s4  <= den_d;
			flag_s4 <= flag_d;
			ax_s4   <= ax_s3;
		end
	end

	always_comb begin
		logic signed [NW-1:0] lo_x, hi_x, e_x, na, nb;
		logic signed [FW-1:0] fv;
		for (int i = 0; i < 3; i++) begin
			lo_x = NW'($signed(lo_s3[i])) <<< FRAC_IN;
			hi_x = NW'($signed(hi_s3[i])) <<< FRAC_IN;
			e_x  = NW'(e_s3[i]);
			fv   = f_s3[i];
			na   = e_x + lo_x;
			nb   = e_x + hi_x;
			mag_d[2*i]   = na[NW-1] ? NW'(-na) : NW'(na);
			mag_d[2*i+1] = nb[NW-1] ? NW'(-nb) : NW'(nb);
			neg_d[2*i]   = na[NW-1] ^ fv[FW-1];
			neg_d[2*i+1] = nb[NW-1] ^ fv[FW-1];
			den_d[2*i]   = fv[FW-1] ? FW'(-fv) : FW'(fv);
			den_d[2*i+1] = den_d[2*i];
			flag_d[i].par      = (fv == '0);
			flag_d[i].par_fail = (lo_x > e_x) || (hi_x < e_x);
		end
	end

	assign out_valid = v_s4;
	assign num_mag   = mag_s4;
	assign num_neg   = neg_s4;
	assign den_mag   = den_s4;
	assign flags     = flag_s4;
	assign axes      = ax_s4;

endmodule

[rtl/rbi_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Carries a sideband word alongside; depends on rbi_pkg.
`timescale 1ns / 1ps

module rbi_divider import rbi_pkg::*; #(
	parameter int NW = 44,
	parameter int FW = 42,
	parameter int SW = 186
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [LANES-1:0][NW-1:0]            num,
	input  logic [LANES-1:0][FW-1:0]            den,
	input  logic [LANES-1:0]                    neg,
	input  logic [SW-1:0]                       side_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [LANES-1:0][NW+FRAC_T-1:0]     quo,
	output logic [LANES-1:0]                    quo_neg,
	output logic [SW-1:0]                       side_out
);

	localparam int QW = NW + FRAC_T;

	logic                        v_s    [QW+1];
	logic [LANES-1:0][QW-1:0]    acc_s  [QW+1];
	logic [LANES-1:0][FW-1:0]    rem_s  [QW+1];
	logic [LANES-1:0][FW-1:0]    den_s  [QW+1];
	logic [LANES-1:0]            neg_s  [QW+1];
	logic [SW-1:0]               side_s [QW+1];
	logic [QW+1:1]               en_c;

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den;
	assign neg_s[0]  = neg;
	assign side_s[0] = side_in;

	for (genvar l = 0; l < LANES; l++) begin : g_load
		assign acc_s[0][l] = {num[l], {FRAC_T{1'b0}}};
	end

	always_comb begin
		en_c[QW+1] = out_ready;
		for (int k = QW; k >= 1; k--) begin
			en_c[k] = !v_s[k] || en_c[k+1];
		end
	end

	assign in_ready = en_c[1];

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [LANES-1:0][FW-1:0] rem_d;
		logic [LANES-1:0][QW-1:0] acc_d;

		always_comb begin
			logic [FW:0] trial;
			for (int l = 0; l < LANES; l++) begin
				trial = {rem_s[k-1][l], acc_s[k-1][l][QW-1]};
				if (trial >= {1'b0, den_s[k-1][l]}) begin
					rem_d[l] = FW'(trial - {1'b0, den_s[k-1][l]});
					acc_d[l] = {acc_s[k-1][l][QW-2:0], 1'b1};
				end else begin
					rem_d[l] = trial[FW-1:0];
					acc_d[l] = {acc_s[k-1][l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en_c[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_c[k]) begin
				rem_s[k]  <= rem_d;
				acc_s[k]  <= acc_d;
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = acc_s[QW];
	assign quo_neg   = neg_s[QW];
	assign side_out  = side_s[QW];

endmodule

[rtl/rbi_resolve.sv]
// Interval narrowing, normal selection and result formatting.
// Three pipeline stages, the last is the output register; depends on rbi_pkg.
`timescale 1ns / 1ps

module rbi_resolve import rbi_pkg::*; #(
	parameter int CB = 20,
	parameter int DB = 32,
	parameter int NW = 44
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [LANES-1:0][NW+FRAC_T-1:0]     quo,
	input  logic [LANES-1:0]                    quo_neg,
	input  axis_flag_t [2:0]                    flags,
	input  logic [2:0][3*CB-1:0]                axes,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [DB-1:0]                       entry_distance,
	output logic [3*CB-1:0]                     surface_normal
);

	localparam int QW = NW + FRAC_T;
	localparam int TW = QW + 2;
	localparam int CW = ((TW > DB) ? TW : DB) + 1;
	localparam logic signed [TW-1:0] T_INF = {2'b01, {QW{1'b1}}};
	localparam logic [CW-1:0] DMAX = {{(CW-DB){1'b0}}, {DB{1'b1}}};
	localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic signed [TW-1:0]   near_d [3], far_d [3], near_s1 [3], far_s1 [3];
	logic [2:0]             pos_d, pos_s1;
	logic [2:0]             fail_s1;
	logic [2:0][3*CB-1:0]   ax_s1;

	logic                   hit_d, hit_s2, pos_sel_d, pos_s2;
	logic signed [TW-1:0]   tmin_d, tmin_s2;
	logic [1:0]             sel_d;
	logic [3*CB-1:0]        axis_d, axis_s2;

	logic                   hit_s3;
	logic [DB-1:0]          dist_d, dist_s3;
	logic [3*CB-1:0]        norm_d, norm_s3;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_comb begin
		logic signed [TW-1:0] ta, tb;
		for (int i = 0; i < 3; i++) begin
			ta = $signed({2'b00, quo[2*i]});
			tb = $signed({2'b00, quo[2*i+1]});
			if (quo_neg[2*i])   ta = -ta;
			if (quo_neg[2*i+1]) tb = -tb;
			if (flags[i].par) begin
				ta = '0;
				tb = T_INF;
			end
			near_d[i] = (ta < tb) ? ta : tb;
			far_d[i]  = (ta < tb) ? tb : ta;
			pos_d[i]  = (tb < ta);
		end
	end

	always_comb begin
		logic signed [TW-1:0] tmax;
		logic                 fail;
		tmin_d = '0;
		tmax   = T_INF;
		fail   = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (near_s1[i] > tmin_d) tmin_d = near_s1[i];
			if (far_s1[i] < tmax)    tmax   = far_s1[i];
			fail = fail || fail_s1[i];
		end
		hit_d = !fail && !(tmax < tmin_d);
		if (near_s1[0] > near_s1[1]) begin
			sel_d = (near_s1[0] > near_s1[2]) ? AXIS_X : AXIS_Z;
		end else begin
			sel_d = (near_s1[1] > near_s1[2]) ? AXIS_Y : AXIS_Z;
		end
		unique case (sel_d)
			AXIS_X: begin
				axis_d    = ax_s1[0];
				pos_sel_d = pos_s1[0];
			end
			AXIS_Y: begin
				axis_d    = ax_s1[1];
				pos_sel_d = pos_s1[1];
			end
			default: begin
				axis_d    = ax_s1[2];
				pos_sel_d = pos_s1[2];
			end
		endcase
	end

	always_comb begin
		logic [CW-1:0] text;
		logic [CB-1:0] c;
		text = {{(CW-TW){1'b0}}, tmin_s2};
		dist_d = (text > DMAX) ? DMAX[DB-1:0] : text[DB-1:0];
		for (int j = 0; j < 3; j++) begin
			c = axis_s2[j*CB +: CB];
			if (!pos_s2) c = (c == CMIN) ? CMAX : CB'(-c);
			norm_d[j*CB +: CB] = c;
		end
		if (!hit_s2) begin
			dist_d = '0;
			norm_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) begin
				near_s1[i] <= near_d[i];
				far_s1[i]  <= far_d[i];
				fail_s1[i] <= flags[i].par && flags[i].par_fail;
			end
			pos_s1 <= pos_d;
			ax_s1  <= axes;
		end
		if (en2) begin
			hit_s2  <= hit_d;
			tmin_s2 <= tmin_d;
			pos_s2  <= pos_sel_d;
			axis_s2 <= axis_d;
		end
		if (en3) begin
			hit_s3  <= hit_s2;
			dist_s3 <= dist_d;
			norm_s3 <= norm_d;
		end
	end

	assign out_valid      = v_s3;
	assign hit            = hit_s3;
	assign entry_distance = dist_s3;
	assign surface_normal = norm_s3;

endmodule

[rtl/ray_box_intersection.sv]
// Ray versus oriented box slab test, fully pipelined, one request per cycle unless the output stalls.
// Data flows through rbi_front, rbi_divider and rbi_resolve in that order.
// Throughput: one request per cycle unless stalled; the bit-per-stage slab dividers set the depth.
// Stalls propagate stage by stage; empty stages fill while the output waits.
// Reset (arst_n, asynchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps

module ray_box_intersection import rbi_pkg::*; #(
	parameter int COMPONENT_BITS = 20,
	parameter int DISTANCE_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [3*COMPONENT_BITS-1:0]   ray_origin,
	input  logic [3*COMPONENT_BITS-1:0]   ray_direction,
	input  logic [3*COMPONENT_BITS-1:0]   box_axis_x,
	input  logic [3*COMPONENT_BITS-1:0]   box_axis_y,
	input  logic [3*COMPONENT_BITS-1:0]   box_axis_z,
	input  logic [3*COMPONENT_BITS-1:0]   box_position,
	input  logic [3*COMPONENT_BITS-1:0]   box_min,
	input  logic [3*COMPONENT_BITS-1:0]   box_max,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [DISTANCE_BITS-1:0]      entry_distance,
	output logic [3*COMPONENT_BITS-1:0]   surface_normal
);

	localparam int CB = COMPONENT_BITS;
	localparam int NW = 2*CB + 4;
	localparam int FW = 2*CB + 2;
	localparam int QW = NW + FRAC_T;
	localparam int SW = 6 + 9*CB;

	logic                       f_valid, f_ready;
	logic [LANES-1:0][NW-1:0]   f_num;
	logic [LANES-1:0]           f_neg;
	logic [LANES-1:0][FW-1:0]   f_den;
	axis_flag_t [2:0]           f_flags;
	logic [2:0][3*CB-1:0]       f_axes;

	logic                       d_valid, d_ready;
	logic [LANES-1:0][QW-1:0]   d_quo;
	logic [LANES-1:0]           d_neg;
	logic [SW-1:0]              d_side;
	axis_flag_t [2:0]           r_flags;
	logic [2:0][3*CB-1:0]       r_axes;

	rbi_front #(.CB(CB)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.ray_origin    (ray_origin),
		.ray_direction (ray_direction),
		.box_axis_x    (box_axis_x),
		.box_axis_y    (box_axis_y),
		.box_axis_z    (box_axis_z),
		.box_position  (box_position),
		.box_min       (box_min),
		.box_max       (box_max),
		.out_valid     (f_valid),
		.out_ready     (f_ready),
		.num_mag       (f_num),
		.num_neg       (f_neg),
		.den_mag       (f_den),
		.flags         (f_flags),
		.axes          (f_axes)
	);

	rbi_divider #(.NW(NW), .FW(FW), .SW(SW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.num       (f_num),
		.den       (f_den),
		.neg       (f_neg),
		.side_in   ({f_axes, f_flags}),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.quo       (d_quo),
		.quo_neg   (d_neg),
		.side_out  (d_side)
	);

	assign {r_axes, r_flags} = d_side;

	rbi_resolve #(.CB(CB), .DB(DISTANCE_BITS), .NW(NW)) u_resolve (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (d_valid),
		.in_ready       (d_ready),
		.quo            (d_quo),
		.quo_neg        (d_neg),
		.flags          (r_flags),
		.axes           (r_axes),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.entry_distance (entry_distance),
		.surface_normal (surface_normal)
	);

endmodule

[rtl/rbi_checker.sv]
// Port-level checker for ray_box_intersection, attached by bind.
// Depends on ray_box_intersection_macros.svh.
`timescale 1ns / 1ps
`include "ray_box_intersection_macros.svh"

module rbi_checker #(
	parameter int COMPONENT_BITS = 20,
	parameter int DISTANCE_BITS  = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          hit,
	input logic [DISTANCE_BITS-1:0]      entry_distance,
	input logic [3*COMPONENT_BITS-1:0]   surface_normal
);

	`RBI_ASSERT_ALWAYS(a_reset_empty, clk, arst_n || !out_valid)
	`RBI_ASSERT_IMPLY(a_miss_dist, clk, arst_n, out_valid && !hit, entry_distance == '0)
	`RBI_ASSERT_IMPLY(a_miss_norm, clk, arst_n, out_valid && !hit, surface_normal == '0)
	`RBI_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(hit) && $stable(entry_distance) && $stable(surface_normal))

endmodule

bind ray_box_intersection rbi_checker #(
	.COMPONENT_BITS (COMPONENT_BITS),
	.DISTANCE_BITS  (DISTANCE_BITS)
) u_rbi_checker (.*);

[dv/ray_box_intersection_test.sv]
// Self-checking testbench for ray_box_intersection: directed and random ray/box requests
// against an in-bench slab-test predictor, with random sender gaps and receiver stalls.
// Depends on rbi_pkg and the ray_box_intersection RTL.
`timescale 1ns / 1ps

module ray_box_intersection_test;
	import rbi_pkg::*;

	localparam int CB = 20;
	localparam int DB = 32;
	localparam int VW = 3 * CB;
	localparam longint T_INF = 64'h7fff_ffff_ffff_ffff;
	localparam int ONE = 1 << FRAC_IN;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [VW-1:0] org, dir, ax, ay, az, pos, bmin, bmax;
	} box_req_t;

	typedef struct {
		logic          hit;
		logic [DB-1:0] entry;
		logic [VW-1:0] normal;
	} box_hit_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [VW-1:0] ray_origin = '0, ray_direction = '0;
	logic [VW-1:0] box_axis_x = '0, box_axis_y = '0, box_axis_z = '0;
	logic [VW-1:0] box_position = '0, box_min = '0, box_max = '0;
	logic out_valid;
	logic out_ready = 0;
	logic hit;
	logic [DB-1:0] entry_distance;
	logic [VW-1:0] surface_normal;

	box_req_t pending_reqs[$];
	box_hit_t expected_hits[$];
	box_req_t cur_req;
	bit stim_loaded = 0;
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0, gap_left = 0;
	int stall_phase = 0, stall_mode = 0;

	ray_box_intersection #(.COMPONENT_BITS(CB), .DISTANCE_BITS(DB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.ray_origin(ray_origin), .ray_direction(ray_direction),
		.box_axis_x(box_axis_x), .box_axis_y(box_axis_y), .box_axis_z(box_axis_z),
		.box_position(box_position), .box_min(box_min), .box_max(box_max),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .entry_distance(entry_distance), .surface_normal(surface_normal)
	);

	always #5 clk = ~clk;

	function automatic longint comp(logic [VW-1:0] v, int j);
		logic signed [CB-1:0] c;
		c = v[j*CB +: CB];
		return longint'(c);
	endfunction

	function automatic logic [VW-1:0] vec3(int x, int y, int z);
		logic [CB-1:0] a, b, c;
		a = CB'(x);
		b = CB'(y);
		c = CB'(z);
		return {c, b, a};
	endfunction

	function automatic longint slab_quotient(longint num, longint den);
		longint unsigned n, d, q;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = (n << FRAC_T) / d;
		return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic box_hit_t trace_box(box_req_t r);
		logic [VW-1:0] axes[3];
		longint t1[3], t2[3];
		longint tmin, tmax, e, f, lo, hi, a, b, nr, fr, nx, ny, nz, c, cmax;
		bit h, pos_sign;
		int sel;
		box_hit_t res;
		axes = '{r.ax, r.ay, r.az};
		tmin = 0;
		tmax = T_INF;
		h = 1;
		cmax = (1 << (CB - 1)) - 1;
		for (int i = 0; i < 3; i++) begin
			t1[i] = 0;
			t2[i] = T_INF;
		end
		for (int i = 0; i < 3 && h; i++) begin
			lo = comp(r.bmin, i) * ONE;
			hi = comp(r.bmax, i) * ONE;
			e = 0;
			f = 0;
			for (int j = 0; j < 3; j++) begin
				e += comp(axes[i], j) * (comp(r.pos, j) - comp(r.org, j));
				f += comp(axes[i], j) * comp(r.dir, j);
			end
			if (f != 0) begin
				a = slab_quotient(e + lo, f);
				b = slab_quotient(e + hi, f);
				nr = a < b ? a : b;
				fr = a < b ? b : a;
				t1[i] = a;
				t2[i] = b;
				if (nr > tmin) tmin = nr;
				if (fr < tmax) tmax = fr;
				if (tmax < tmin) h = 0;
			end else if (lo - e > 0 || hi - e < 0) begin
				h = 0;
			end
		end
		res.hit = h;
		res.entry = '0;
		res.normal = '0;
		if (h) begin
			nx = t1[0] < t2[0] ? t1[0] : t2[0];
			ny = t1[1] < t2[1] ? t1[1] : t2[1];
			nz = t1[2] < t2[2] ? t1[2] : t2[2];
			if (nx > ny) sel = (nx > nz) ? 0 : 2;
			else sel = (ny > nz) ? 1 : 2;
			pos_sign = t2[sel] < t1[sel];
			for (int j = 0; j < 3; j++) begin
				c = comp(axes[sel], j);
				if (!pos_sign) c = (c < -cmax) ? cmax : -c;
				res.normal[j*CB +: CB] = c[CB-1:0];
			end
			res.entry = (tmin > longint'({DB{1'b1}})) ? {DB{1'b1}} : tmin[DB-1:0];
		end
		return res;
	endfunction

	function automatic logic [VW-1:0] rand_vec();
		return VW'({$urandom, $urandom});
	endfunction

	function automatic int rand_comp(int span);
		return $urandom_range(2 * span) - span;
	endfunction

	function automatic logic [VW-1:0] rand_small(int span);
		return vec3(rand_comp(span), rand_comp(span), rand_comp(span));
	endfunction

	function automatic logic [VW-1:0] unit_axis(int k, bit neg);
		int v;
		v = neg ? -ONE : ONE;
		return vec3(k == 0 ? v : 0, k == 1 ? v : 0, k == 2 ? v : 0);
	endfunction

	task automatic add_req(logic [VW-1:0] org, dir, ax, ay, az, pos, bmin, bmax);
		box_req_t r;
		r = '{org, dir, ax, ay, az, pos, bmin, bmax};
		pending_reqs.push_back(r);
	endtask

	task automatic add_aligned(logic [VW-1:0] org, dir, bmin, bmax);
		add_req(org, dir, unit_axis(0, 0), unit_axis(1, 0), unit_axis(2, 0), '0, bmin, bmax);
	endtask

	task automatic add_random_scene();
		int perm, sx, sy, sz, k;
		logic [VW-1:0] ax[3], bmin, bmax, pos, org, dir;
		int lo[3], hi[3];
		perm = $urandom_range(5);
		for (int i = 0; i < 3; i++) begin
			k = (perm + i * (perm % 2 ? 2 : 1)) % 3;
			ax[i] = ($urandom_range(3) == 0) ? rand_small(ONE) : unit_axis(k, $urandom_range(1));
			lo[i] = rand_comp(8 * ONE);
			hi[i] = lo[i] + $urandom_range(8 * ONE);
		end
		bmin = vec3(lo[0], lo[1], lo[2]);
		bmax = vec3(hi[0], hi[1], hi[2]);
		pos = rand_small(16 * ONE);
		org = rand_small(64 * ONE);
		sx = int'(comp(pos, 0) - comp(org, 0)) + rand_comp(4 * ONE);
		sy = int'(comp(pos, 1) - comp(org, 1)) + rand_comp(4 * ONE);
		sz = int'(comp(pos, 2) - comp(org, 2)) + rand_comp(4 * ONE);
		case ($urandom_range(5))
			0: dir = vec3(0, sy / 16, sz / 16);
			1: dir = '0;
			2: dir = rand_small(ONE);
			default: dir = vec3(sx / 16, sy / 16, sz / 16);
		endcase
		add_req(org, dir, ax[0], ax[1], ax[2], pos, bmin, bmax);
	endtask

	initial begin
		logic [VW-1:0] mn, mx, cube_lo, cube_hi;
		mn = vec3(-(1 << 19), -(1 << 19), -(1 << 19));
		mx = vec3((1 << 19) - 1, (1 << 19) - 1, (1 << 19) - 1);
		cube_lo = vec3(-ONE, -ONE, -ONE);
		cube_hi = vec3(ONE, ONE, ONE);
		add_req('0, '0, '0, '0, '0, '0, '0, '0);
		add_req({VW{1'b1}}, {VW{1'b1}}, {VW{1'b1}}, {VW{1'b1}}, {VW{1'b1}},
			{VW{1'b1}}, {VW{1'b1}}, {VW{1'b1}});
		add_aligned(vec3(-8 * ONE, 0, 0), vec3(ONE, 0, 0), cube_lo, cube_hi);
		add_aligned(vec3(8 * ONE, 0, 0), vec3(-ONE, 0, 0), cube_lo, cube_hi);
		add_aligned(vec3(0, -8 * ONE, 0), vec3(0, ONE, 0), cube_lo, cube_hi);
		add_aligned(vec3(0, 0, 8 * ONE), vec3(0, 0, -ONE), cube_lo, cube_hi);
		add_aligned(vec3(0, 4 * ONE, -8 * ONE), vec3(0, 0, ONE), cube_lo, cube_hi);
		add_aligned(vec3(0, ONE, -8 * ONE), vec3(0, 0, ONE), cube_lo, cube_hi);
		add_aligned(vec3(0, 0, 8 * ONE), vec3(0, 0, ONE), cube_lo, cube_hi);
		add_aligned('0, vec3(ONE, 0, 0), cube_lo, cube_hi);
		add_aligned(vec3(-4 * ONE, -4 * ONE, -4 * ONE), vec3(ONE, ONE, ONE), cube_lo, cube_hi);
		add_aligned(vec3(-4 * ONE, -4 * ONE, 0), vec3(ONE, ONE, 0), cube_lo, cube_hi);
		add_aligned(mn, vec3(1, 1, 1), mn, mx);
		add_aligned(vec3(-(1 << 19), 0, 0), vec3(1, 0, 0), mx, mx);
		add_req(vec3(-8 * ONE, 0, 0), vec3(ONE, 0, 0), mn, unit_axis(1, 0), unit_axis(2, 0),
			'0, cube_lo, cube_hi);
		add_req(vec3(8 * ONE, 0, 0), vec3(ONE, 0, 0), mn, mn, mn, '0, mn, mx);
		add_req(mx, mn, mx, mn, mx, mn, mn, mx);
		add_req(mn, mx, mn, mx, mn, mx, mn, mx);
		add_aligned(vec3(-8 * ONE, 0, 0), vec3(1, 0, 0), cube_lo, cube_hi);
		add_aligned(vec3(0, 0, 0), '0, cube_lo, cube_hi);
		add_aligned(vec3(2 * ONE, 0, 0), '0, cube_lo, cube_hi);
		add_aligned(vec3(ONE, ONE, ONE), vec3(-ONE, 0, 0), cube_lo, cube_hi);
		for (int i = 0; i < 1500; i++) begin
			if ($urandom_range(3) == 0)
				add_req(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec(),
					rand_vec(), rand_vec(), rand_vec());
			else
				add_random_scene();
		end
		stim_loaded = 1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		do @(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_hits.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_hits.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// sender: bursts with random gaps
	always @(posedge clk) begin
		bit drive_next;
		if (arst_n && stim_loaded) begin
			if (in_valid && in_ready) expected_hits.push_back(trace_box(cur_req));
			drive_next = 0;
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					ray_origin <= cur_req.org;
					ray_direction <= cur_req.dir;
					box_axis_x <= cur_req.ax;
					box_axis_y <= cur_req.ay;
					box_axis_z <= cur_req.az;
					box_position <= cur_req.pos;
					box_min <= cur_req.bmin;
					box_max <= cur_req.bmax;
					drive_next = 1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1) ? $urandom_range(8) : $urandom_range(200);
						gap_left = $urandom_range(2) == 0 ? 0 : $urandom_range(6);
					end
				end
				in_valid <= drive_next;
			end
		end
	end

	// receiver: out_ready pattern set by a randomly reselected stall mode
	always @(posedge clk) begin
		if (arst_n) begin
			stall_phase++;
			if (stall_phase % 300 == 0) stall_mode = $urandom_range(3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(1);
				2: out_ready <= ($urandom_range(7) == 0);
				default: out_ready <= ((stall_phase % 7) < 4);
			endcase
		end
	end

	always @(posedge clk) begin
		box_hit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hit=%0d dist=%h normal=%h",
						hit, entry_distance, surface_normal);
			end else begin
				want = expected_hits.pop_front();
				if (hit !== want.hit || entry_distance !== want.entry ||
						surface_normal !== want.normal) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit=%0d dist=%h normal=%h, got hit=%0d dist=%h normal=%h",
							want.hit, want.entry, want.normal,
							hit, entry_distance, surface_normal);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

[ray_box_intersection.f]
+incdir+rtl
rtl/rbi_pkg.sv
rtl/rbi_front.sv
rtl/rbi_divider.sv
rtl/rbi_resolve.sv
rtl/ray_box_intersection.sv
rtl/rbi_checker.sv
dv/ray_box_intersection_test.sv
